// ===== hw/rtl/gfsc_pkg.sv =====
// Package for the GPIO function-select / set-clear register block.
// Holds the request type, word index codes, widths and the field mask helper.
// No dependencies; every RTL file of the block refers to it by scoped name.
`default_nettype none

package gfsc_pkg;

  localparam int PIN_COUNT_DEF = 54;
  localparam int MAX_PINS      = 64;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 6;
  localparam int LEVELS_HI_W   = 22;
  localparam int PULL_LO_W     = 64;
  localparam int PULL_HI_W     = 44;
  localparam int PULL_W        = 2;

  // Function select: ten 3-bit fields per word, six words.
  localparam int FSEL_CODE_W   = 3;
  localparam int FSEL_PER_WORD = 10;
  localparam int FSEL_WORDS    = 6;
  localparam int FSEL_W        = FSEL_CODE_W * FSEL_PER_WORD;
  localparam int FSEL_SEL_W    = $clog2(FSEL_WORDS);

  // Bus access kind.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register word indexes.
  localparam logic [IDX_W-1:0] WI_FSEL_FIRST = 6'd0;
  localparam logic [IDX_W-1:0] WI_FSEL_LAST  = 6'd5;
  localparam logic [IDX_W-1:0] WI_SET_LO     = 6'd7;
  localparam logic [IDX_W-1:0] WI_SET_HI     = 6'd8;
  localparam logic [IDX_W-1:0] WI_CLR_LO     = 6'd10;
  localparam logic [IDX_W-1:0] WI_CLR_HI     = 6'd11;
  localparam logic [IDX_W-1:0] WI_PULL       = 6'd37;
  localparam logic [IDX_W-1:0] WI_PCLK_LO    = 6'd38;
  localparam logic [IDX_W-1:0] WI_PCLK_HI    = 6'd39;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  word_index;
    logic [DATA_W-1:0] write_data;
  } req_t;

  // Mask of the function-select fields of one word that belong to real pins.
  function automatic logic [FSEL_W-1:0] fsel_mask(input logic [FSEL_SEL_W-1:0] word,
                                                  input int pin_count);
    logic [FSEL_W-1:0] m;
    int                pin;
    m = '0;
    for (int k = 0; k < FSEL_PER_WORD; k++) begin
      pin = int'(word) * FSEL_PER_WORD + k;
      if (pin < pin_count) begin
        m[k*FSEL_CODE_W +: FSEL_CODE_W] = {FSEL_CODE_W{1'b1}};
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gfsc_in_stage.sv =====
// Input register of the GPIO register block: captures one bus request.
// Depends on gfsc_pkg for the request type.
`default_nettype none

module gfsc_in_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          in_op,
  input  wire logic [gfsc_pkg::IDX_W-1:0]    in_word_index,
  input  wire logic [gfsc_pkg::DATA_W-1:0]   in_write_data,
  input  wire logic                          adv,
  output logic                               req_valid,
  output gfsc_pkg::req_t                     req
);

  logic           valid_r;
  logic           valid_nxt;
  gfsc_pkg::req_t req_r;
  logic           accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset; load only on an accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op         <= in_op;
      req_r.word_index <= in_word_index;
      req_r.write_data <= in_write_data;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gfsc_regfile.sv =====
// Register file of the GPIO block: function select, output latch, pull control,
// pull clock and per-pin pull state, plus the registered read data.
// Depends on gfsc_pkg for the request type, word codes and field masks.
`default_nettype none

module gfsc_regfile #(
  parameter int PIN_COUNT = gfsc_pkg::PIN_COUNT_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     adv,
  input  wire gfsc_pkg::req_t                           req,
  output logic [gfsc_pkg::DATA_W-1:0]                   read_data,
  output logic [gfsc_pkg::MAX_PINS-1:0]                 latch_ext,
  output logic [gfsc_pkg::PULL_W*gfsc_pkg::MAX_PINS-1:0] pull_ext
);

  localparam int PullVecW = gfsc_pkg::PULL_W * PIN_COUNT;
  localparam int HalfW    = gfsc_pkg::MAX_PINS / 2;

  logic [gfsc_pkg::FSEL_W-1:0]     fsel_r [gfsc_pkg::FSEL_WORDS];
  logic [PIN_COUNT-1:0]            latch_r, latch_nxt;
  logic [PIN_COUNT-1:0]            pclk_r, pclk_nxt;
  logic [gfsc_pkg::PULL_W-1:0]     ctrl_r, ctrl_nxt;
  logic [PullVecW-1:0]             pull_r, pull_nxt;
  logic [gfsc_pkg::DATA_W-1:0]     rdata_r, rdata_nxt;

  logic                            is_write;
  logic                            fsel_we;
  logic [gfsc_pkg::FSEL_SEL_W-1:0] fsel_sel;
  logic [gfsc_pkg::MAX_PINS-1:0]   data_lo, data_hi, pclk_wide;

  assign is_write  = (req.op == gfsc_pkg::OP_WRITE);
  assign fsel_sel  = req.word_index[gfsc_pkg::FSEL_SEL_W-1:0];
  assign data_lo   = {{HalfW{1'b0}}, req.write_data};
  assign data_hi   = {req.write_data, {HalfW{1'b0}}};
  assign pclk_wide = gfsc_pkg::MAX_PINS'(pclk_r);

  always_comb begin
    latch_nxt = latch_r;
    pclk_nxt  = pclk_r;
    ctrl_nxt  = ctrl_r;
    rdata_nxt = '0;
    fsel_we   = 1'b0;

    if (is_write) begin
      case (req.word_index) inside
        [gfsc_pkg::WI_FSEL_FIRST:gfsc_pkg::WI_FSEL_LAST]: fsel_we = 1'b1;
        gfsc_pkg::WI_SET_LO:  latch_nxt = latch_r | PIN_COUNT'(data_lo);
        gfsc_pkg::WI_SET_HI:  latch_nxt = latch_r | PIN_COUNT'(data_hi);
        gfsc_pkg::WI_CLR_LO:  latch_nxt = latch_r & ~PIN_COUNT'(data_lo);
        gfsc_pkg::WI_CLR_HI:  latch_nxt = latch_r & ~PIN_COUNT'(data_hi);
        gfsc_pkg::WI_PULL:    ctrl_nxt  = req.write_data[gfsc_pkg::PULL_W-1:0];
        gfsc_pkg::WI_PCLK_LO: pclk_nxt  = PIN_COUNT'({pclk_wide[gfsc_pkg::MAX_PINS-1:HalfW],
                                                      req.write_data});
        gfsc_pkg::WI_PCLK_HI: pclk_nxt  = PIN_COUNT'({req.write_data,
                                                      pclk_wide[HalfW-1:0]});
        default: ;
      endcase
    end else begin
      case (req.word_index) inside
        [gfsc_pkg::WI_FSEL_FIRST:gfsc_pkg::WI_FSEL_LAST]:
          rdata_nxt = gfsc_pkg::DATA_W'(fsel_r[fsel_sel]);
        gfsc_pkg::WI_PULL:    rdata_nxt = gfsc_pkg::DATA_W'(ctrl_r);
        gfsc_pkg::WI_PCLK_LO: rdata_nxt = pclk_wide[HalfW-1:0];
        gfsc_pkg::WI_PCLK_HI: rdata_nxt = pclk_wide[gfsc_pkg::MAX_PINS-1:HalfW];
        default: ;
      endcase
    end

    // Every clocked pin follows the pull value after the access.
    pull_nxt = pull_r;
    for (int p = 0; p < PIN_COUNT; p++) begin
      if (pclk_nxt[p]) begin
        pull_nxt[p*gfsc_pkg::PULL_W +: gfsc_pkg::PULL_W] = ctrl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
      pclk_r  <= '0;
      ctrl_r  <= '0;
      pull_r  <= '0;
      for (int w = 0; w < gfsc_pkg::FSEL_WORDS; w++) begin
        fsel_r[w] <= '0;
      end
    end else if (adv) begin
      latch_r <= latch_nxt;
      pclk_r  <= pclk_nxt;
      ctrl_r  <= ctrl_nxt;
      pull_r  <= pull_nxt;
      if (fsel_we) begin
        fsel_r[fsel_sel] <= req.write_data[gfsc_pkg::FSEL_W-1:0] &
                            gfsc_pkg::fsel_mask(fsel_sel, PIN_COUNT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= rdata_nxt;
    end
  end

  assign read_data = rdata_r;
  assign latch_ext = gfsc_pkg::MAX_PINS'(latch_r);
  assign pull_ext  = (gfsc_pkg::PULL_W * gfsc_pkg::MAX_PINS)'(pull_r);

endmodule

`default_nettype wire

// ===== hw/rtl/gpio_function_select_set_clear.sv =====
// GPIO register block (function select, set/clear output latch, clocked pull).
// Throughput 1 request per cycle while out_stall is low; read data has no reset.
// One input register and one result register; the state updates as a request moves on.
// Synchronous active-low reset clears valids and state; levels and pull states read 0.
// Depends on gfsc_pkg, gfsc_in_stage and gfsc_regfile.
`default_nettype none

module gpio_function_select_set_clear #(
  parameter int PIN_COUNT = gfsc_pkg::PIN_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Request channel: one bus access.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_op,
  input  wire logic [gfsc_pkg::IDX_W-1:0]        in_word_index,
  input  wire logic [gfsc_pkg::DATA_W-1:0]       in_write_data,
  // Result channel: read data plus the pin-facing state after the access.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [gfsc_pkg::DATA_W-1:0]            out_read_data,
  output logic [gfsc_pkg::DATA_W-1:0]            out_levels_lo,
  output logic [gfsc_pkg::LEVELS_HI_W-1:0]       out_levels_hi,
  output logic [gfsc_pkg::PULL_LO_W-1:0]         out_pull_state_lo,
  output logic [gfsc_pkg::PULL_HI_W-1:0]         out_pull_state_hi
);

  localparam int HalfW = gfsc_pkg::MAX_PINS / 2;

  logic                                           req_valid;
  gfsc_pkg::req_t                                 req;
  logic                                           out_valid_r;
  logic                                           out_valid_nxt;
  logic                                           out_free;
  logic                                           adv;
  logic [gfsc_pkg::MAX_PINS-1:0]                  latch_ext;
  logic [gfsc_pkg::PULL_W*gfsc_pkg::MAX_PINS-1:0] pull_ext;

  // The result slot is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Advance the held request into the result slot whenever there is room.
  assign adv      = req_valid && out_free;
  // Stall only when the input register is full and cannot advance.
  assign in_stall = req_valid && !out_free;

  gfsc_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_word_index (in_word_index),
    .in_write_data (in_write_data),
    .adv           (adv),
    .req_valid     (req_valid),
    .req           (req)
  );

  // State registers double as the result register for the pin-facing fields:
  // they change only on an advance, which is exactly when a new result is shown.
  gfsc_regfile #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req       (req),
    .read_data (out_read_data),
    .latch_ext (latch_ext),
    .pull_ext  (pull_ext)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  // Drop latch and pull bits beyond the visible pin range.
  assign out_levels_lo     = latch_ext[HalfW-1:0];
  assign out_levels_hi     = latch_ext[HalfW +: gfsc_pkg::LEVELS_HI_W];
  assign out_pull_state_lo = pull_ext[gfsc_pkg::PULL_LO_W-1:0];
  assign out_pull_state_hi = pull_ext[gfsc_pkg::PULL_LO_W +: gfsc_pkg::PULL_HI_W];

endmodule

`default_nettype wire

// ===== hw/rtl/gfsc_chk.sv =====
// Port-level checker for the GPIO register block, bound to the top level.
// Depends on gfsc_pkg for port widths.
`default_nettype none

module gfsc_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [gfsc_pkg::DATA_W-1:0]       out_read_data,
  input wire logic [gfsc_pkg::DATA_W-1:0]       out_levels_lo,
  input wire logic [gfsc_pkg::PULL_LO_W-1:0]    out_pull_state_lo
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

  // Never stall a request while the result slot is empty.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("request stalled with empty result slot");

  // A new result comes from a request accepted into the input register and then advanced.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a request");

  // Latch and pull state come out of reset cleared.
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_levels_lo == '0 && out_pull_state_lo == '0 && !out_valid)
    else $error("state not cleared by reset");

endmodule

bind gpio_function_select_set_clear gfsc_chk u_gfsc_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_read_data     (out_read_data),
  .out_levels_lo     (out_levels_lo),
  .out_pull_state_lo (out_pull_state_lo)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the GPIO function-select / set-clear register block.
// Drives bus requests, predicts every result from its own register image, compares fields.
// Depends on gfsc_pkg and gpio_function_select_set_clear.
`timescale 1ns / 1ps

module tb_top;

  localparam int NPINS      = gfsc_pkg::PIN_COUNT_DEF;
  localparam int HOLD_LEN   = 80;      // long receiver hold-off, in cycles
  localparam int CYCLE_MAX  = 200000;  // generous run limit
  localparam int DRAIN_WAIT = 10;      // cycles to linger once nothing is pending

  // Middle function-select words and words that decode to nothing.
  localparam logic [gfsc_pkg::IDX_W-1:0] WI_FSEL_1   = 6'd1;
  localparam logic [gfsc_pkg::IDX_W-1:0] WI_FSEL_2   = 6'd2;
  localparam logic [gfsc_pkg::IDX_W-1:0] WI_FSEL_3   = 6'd3;
  localparam logic [gfsc_pkg::IDX_W-1:0] WI_FSEL_4   = 6'd4;
  localparam logic [gfsc_pkg::IDX_W-1:0] WI_RSVD_LO  = 6'd6;
  localparam logic [gfsc_pkg::IDX_W-1:0] WI_RSVD_MID = 6'd9;
  localparam logic [gfsc_pkg::IDX_W-1:0] WI_RSVD_TOP = 6'd63;

  // Pin-facing view of the block after one request.
  typedef struct packed {
    logic [gfsc_pkg::DATA_W-1:0]      rd;
    logic [gfsc_pkg::DATA_W-1:0]      lvl_lo;
    logic [gfsc_pkg::LEVELS_HI_W-1:0] lvl_hi;
    logic [gfsc_pkg::PULL_LO_W-1:0]   pull_lo;
    logic [gfsc_pkg::PULL_HI_W-1:0]   pull_hi;
  } gpio_view_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_op;
  logic [gfsc_pkg::IDX_W-1:0]       in_word_index;
  logic [gfsc_pkg::DATA_W-1:0]      in_write_data;
  logic                             out_valid;
  logic                             out_stall;
  logic [gfsc_pkg::DATA_W-1:0]      out_read_data;
  logic [gfsc_pkg::DATA_W-1:0]      out_levels_lo;
  logic [gfsc_pkg::LEVELS_HI_W-1:0] out_levels_hi;
  logic [gfsc_pkg::PULL_LO_W-1:0]   out_pull_state_lo;
  logic [gfsc_pkg::PULL_HI_W-1:0]   out_pull_state_hi;

  gpio_function_select_set_clear u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_word_index     (in_word_index),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_levels_lo     (out_levels_lo),
    .out_levels_hi     (out_levels_hi),
    .out_pull_state_lo (out_pull_state_lo),
    .out_pull_state_hi (out_pull_state_hi)
  );

  // Register image kept by the predictor.
  logic [gfsc_pkg::FSEL_CODE_W-1:0] img_fsel [NPINS];
  logic [NPINS-1:0]                 img_latch;
  logic [gfsc_pkg::PULL_W-1:0]      img_pull_ctl;
  logic [NPINS-1:0]                 img_pull_clk;
  logic [gfsc_pkg::PULL_W-1:0]      img_pull_st [NPINS];

  gpio_view_t pending_views[$];

  int  errors;
  int  sent_count;
  int  checked_count;
  int  cycles;
  bit  idle_on;       // random gaps on both sides
  int  hold_reqs;     // bumped by a test to request a long hold-off
  int  hold_seen;
  int  hold_left;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Count cycles and bail out if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("%0t: timeout with %0d results still pending", $time, pending_views.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when a test asks.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 8);
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest pending view.
  always @(posedge clk) begin
    gpio_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        $display("%0t: result with nothing pending, read_data %h", $time, out_read_data);
        errors++;
      end else begin
        want = pending_views.pop_front();
        check_field("read_data",     want.rd,      out_read_data);
        check_field("levels_lo",     want.lvl_lo,  out_levels_lo);
        check_field("levels_hi",     want.lvl_hi,  out_levels_hi);
        check_field("pull_state_lo", want.pull_lo, out_pull_state_lo);
        check_field("pull_state_hi", want.pull_hi, out_pull_state_hi);
        checked_count++;
      end
    end
  end

  // Apply one bus access to the register image and return what the pins show after it.
  function automatic gpio_view_t apply_access(input logic op,
                                              input logic [gfsc_pkg::IDX_W-1:0] idx,
                                              input logic [gfsc_pkg::DATA_W-1:0] data);
    gpio_view_t v;
    int         pin;
    v = '0;
    if (op == gfsc_pkg::OP_WRITE) begin
      if (idx <= gfsc_pkg::WI_FSEL_LAST) begin
        for (int k = 0; k < gfsc_pkg::FSEL_PER_WORD; k++) begin
          pin = int'(idx) * gfsc_pkg::FSEL_PER_WORD + k;
          if (pin < NPINS) begin
            img_fsel[pin] = data[k*gfsc_pkg::FSEL_CODE_W +: gfsc_pkg::FSEL_CODE_W];
          end
        end
      end else begin
        case (idx)
          gfsc_pkg::WI_SET_LO:  img_latch[31:0] = img_latch[31:0] | data;
          gfsc_pkg::WI_SET_HI:  img_latch[NPINS-1:32] = img_latch[NPINS-1:32] |
                                                        data[NPINS-33:0];
          gfsc_pkg::WI_CLR_LO:  img_latch[31:0] = img_latch[31:0] & ~data;
          gfsc_pkg::WI_CLR_HI:  img_latch[NPINS-1:32] = img_latch[NPINS-1:32] &
                                                        ~data[NPINS-33:0];
          gfsc_pkg::WI_PULL:    img_pull_ctl = data[gfsc_pkg::PULL_W-1:0];
          gfsc_pkg::WI_PCLK_LO: img_pull_clk[31:0] = data;
          gfsc_pkg::WI_PCLK_HI: img_pull_clk[NPINS-1:32] = data[NPINS-33:0];
          default: ;
        endcase
      end
    end else begin
      if (idx <= gfsc_pkg::WI_FSEL_LAST) begin
        for (int k = 0; k < gfsc_pkg::FSEL_PER_WORD; k++) begin
          pin = int'(idx) * gfsc_pkg::FSEL_PER_WORD + k;
          if (pin < NPINS) begin
            v.rd[k*gfsc_pkg::FSEL_CODE_W +: gfsc_pkg::FSEL_CODE_W] = img_fsel[pin];
          end
        end
      end else begin
        case (idx)
          gfsc_pkg::WI_PULL:    v.rd[gfsc_pkg::PULL_W-1:0] = img_pull_ctl;
          gfsc_pkg::WI_PCLK_LO: v.rd                       = img_pull_clk[31:0];
          gfsc_pkg::WI_PCLK_HI: v.rd[NPINS-33:0]           = img_pull_clk[NPINS-1:32];
          default: ;
        endcase
      end
    end
    // Clocked pins pick up the pull value after every access.
    for (int p = 0; p < NPINS; p++) begin
      if (img_pull_clk[p]) img_pull_st[p] = img_pull_ctl;
    end
    v.lvl_lo = img_latch[31:0];
    v.lvl_hi = img_latch[NPINS-1:32];
    for (int p = 0; p < NPINS; p++) begin
      if (p < 32) v.pull_lo[2*p +: 2] = img_pull_st[p];
      else        v.pull_hi[2*(p-32) +: 2] = img_pull_st[p];
    end
    return v;
  endfunction

  // Offer one request; return once it has been accepted. Valid stays high afterwards
  // so back-to-back requests never drop it.
  task automatic send_req(input logic op, input logic [gfsc_pkg::IDX_W-1:0] idx,
                          input logic [gfsc_pkg::DATA_W-1:0] data);
    int gap;
    if (idle_on && ($urandom_range(0, 99) < 8)) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_word_index <= idx;
    in_write_data <= data;
    do @(posedge clk); while (in_stall);
    pending_views.push_back(apply_access(op, idx, data));
    sent_count++;
  endtask

  // Drop valid and hold the sender until every pending result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  function automatic logic [gfsc_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [gfsc_pkg::IDX_W-1:0] rand_index();
    logic [gfsc_pkg::IDX_W-1:0] live [13] = '{gfsc_pkg::WI_FSEL_FIRST, WI_FSEL_1,
                                              WI_FSEL_2, WI_FSEL_3, WI_FSEL_4,
                                              gfsc_pkg::WI_FSEL_LAST,
                                              gfsc_pkg::WI_SET_LO, gfsc_pkg::WI_SET_HI,
                                              gfsc_pkg::WI_CLR_LO, gfsc_pkg::WI_CLR_HI,
                                              gfsc_pkg::WI_PULL, gfsc_pkg::WI_PCLK_LO,
                                              gfsc_pkg::WI_PCLK_HI};
    if ($urandom_range(0, 99) < 75) return live[$urandom_range(0, 12)];
    return gfsc_pkg::IDX_W'($urandom_range(0, 63));
  endfunction

  // Reset values of the first and last function-select words, the pull words and a reserved one.
  task automatic test_reset_values();
    send_req(gfsc_pkg::OP_READ, gfsc_pkg::WI_FSEL_FIRST, '0);
    send_req(gfsc_pkg::OP_READ, gfsc_pkg::WI_FSEL_LAST, '0);
    send_req(gfsc_pkg::OP_READ, gfsc_pkg::WI_PULL, '0);
    send_req(gfsc_pkg::OP_READ, gfsc_pkg::WI_PCLK_LO, '0);
    send_req(gfsc_pkg::OP_READ, gfsc_pkg::WI_PCLK_HI, '0);
    send_req(gfsc_pkg::OP_READ, WI_RSVD_LO, '0);
  endtask

  // All-ones writes expose the reserved top bits and the short last word.
  task automatic test_function_select();
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_FSEL_FIRST, '1);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_FSEL_LAST, '1);
    send_req(gfsc_pkg::OP_READ,  gfsc_pkg::WI_FSEL_FIRST, '0);
    send_req(gfsc_pkg::OP_READ,  gfsc_pkg::WI_FSEL_LAST, '0);
    send_req(gfsc_pkg::OP_WRITE, WI_FSEL_3, 32'h2AAA_AAAA);
    send_req(gfsc_pkg::OP_READ,  WI_FSEL_3, '0);
  endtask

  // Write-one set and clear, including bits past the last pin and a zero write.
  task automatic test_set_clear();
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_SET_LO, '1);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_SET_HI, '1);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_CLR_LO, 32'hAAAA_AAAA);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_SET_LO, '0);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_CLR_HI, '1);
    send_req(gfsc_pkg::OP_READ,  gfsc_pkg::WI_SET_LO, '0);
  endtask

  // Pull value keeps two bits; clocked pins follow it, unclocked pins hold.
  task automatic test_pull_clock();
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_PULL, '1);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_PCLK_LO, '1);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_PCLK_HI, '1);
    send_req(gfsc_pkg::OP_READ,  gfsc_pkg::WI_PULL, '0);
    send_req(gfsc_pkg::OP_READ,  gfsc_pkg::WI_PCLK_HI, '0);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_PCLK_LO, '0);
    send_req(gfsc_pkg::OP_WRITE, gfsc_pkg::WI_PULL, 32'h1);
  endtask

  // Words that decode to nothing ignore writes and read zero.
  task automatic test_unused_words();
    send_req(gfsc_pkg::OP_WRITE, WI_RSVD_TOP, '1);
    send_req(gfsc_pkg::OP_READ,  WI_RSVD_TOP, '0);
    send_req(gfsc_pkg::OP_READ,  WI_RSVD_MID, '0);
  endtask

  // Random accesses: mostly live words, some noise across the whole index space.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      // Leave a long stretch in the middle without any idling.
      idle_on = !(i >= count / 3 && i < count / 3 + 120);
      send_req(($urandom_range(0, 99) < 60) ? gfsc_pkg::OP_WRITE : gfsc_pkg::OP_READ,
               rand_index(), rand_word());
    end
    idle_on = 1'b1;
  endtask

  // Hold the receiver off while requests keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 20; i++) begin
      send_req(($urandom_range(0, 1) != 0) ? gfsc_pkg::OP_WRITE : gfsc_pkg::OP_READ,
               rand_index(), rand_word());
    end
    wait_drained();
  endtask

  initial begin
    errors        = 0;
    sent_count    = 0;
    checked_count = 0;
    cycles        = 0;
    idle_on       = 1'b1;
    hold_reqs     = 0;
    hold_seen     = 0;
    hold_left     = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = gfsc_pkg::OP_READ;
    in_word_index = '0;
    in_write_data = '0;
    out_stall     = 1'b0;
    for (int p = 0; p < NPINS; p++) begin
      img_fsel[p]    = '0;
      img_pull_st[p] = '0;
    end
    img_latch    = '0;
    img_pull_ctl = '0;
    img_pull_clk = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_function_select();
    test_set_clear();
    test_pull_clock();
    test_unused_words();
    wait_drained();
    test_backpressure();
    test_random(470);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d bus requests (fsel, set/clear, pull, pull clock, unused words),",
             sent_count);
    $display("%0d results checked, with random gaps and a long receiver hold-off.",
             checked_count);
    if (errors == 0 && pending_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== gpio_function_select_set_clear.f =====
hw/rtl/gfsc_pkg.sv
hw/rtl/gfsc_in_stage.sv
hw/rtl/gfsc_regfile.sv
hw/rtl/gpio_function_select_set_clear.sv
hw/rtl/gfsc_chk.sv
sim/tb_top.sv
